// ===== design/gpcc_pkg.sv =====
// Shared types, constants and helpers for the paired genotype concordance counter.
`default_nettype none
package gpcc_pkg;

  localparam int CNT_W   = 32;
  localparam int NUM_CNT = 28;
  localparam int IDX_W   = 5;
  localparam logic [7:0] BASE_N = 8'h4E;

  // Counter indexes
  localparam logic [IDX_W-1:0] IX_MAPPED       = 5'd0;
  localparam logic [IDX_W-1:0] IX_CALLED       = 5'd2;
  localparam logic [IDX_W-1:0] IX_SNP          = 5'd4;
  localparam logic [IDX_W-1:0] IX_SNP_HET      = 5'd6;
  localparam logic [IDX_W-1:0] IX_SOME_MAPPED  = 5'd8;
  localparam logic [IDX_W-1:0] IX_ALL_MAPPED   = 5'd9;
  localparam logic [IDX_W-1:0] IX_SOME_CALLED  = 5'd10;
  localparam logic [IDX_W-1:0] IX_ALL_CALLED   = 5'd11;
  localparam logic [IDX_W-1:0] IX_AGREE        = 5'd12;
  localparam logic [IDX_W-1:0] IX_CONFLICT     = 5'd13;
  localparam logic [IDX_W-1:0] IX_AGREE_HET    = 5'd14;
  localparam logic [IDX_W-1:0] IX_AGREE_HOM    = 5'd16;
  localparam logic [IDX_W-1:0] IX_AGREE_CAT    = 5'd18;
  localparam logic [IDX_W-1:0] IX_CONFLICT_CAT = 5'd23;

  typedef enum logic [2:0] {
    SC_SKIPPED   = 3'd0,
    SC_NOT_BOTH  = 3'd1,
    SC_REF_AGREE = 3'd2,
    SC_VAR_AGREE = 3'd3,
    SC_CONFLICT  = 3'd4
  } site_class_e;

  typedef enum logic [2:0] {
    CAT_SAMEHOM = 3'd0,
    CAT_DIFFHOM = 3'd1,
    CAT_SAMEHET = 3'd2,
    CAT_DIFFHET = 3'd3,
    CAT_HOMHET  = 3'd4,
    CAT_NONE    = 3'd5
  } pair_cat_e;

  typedef logic [NUM_CNT-1:0] bump_mask_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // One classified transaction waiting for the counter bank
  typedef struct packed {
    logic        is_read;
    logic [IDX_W-1:0] idx;
    site_class_e site_class;
    pair_cat_e   cat;
    bump_mask_t  mask;
  } work_t;

  // Hom/het category of a called pair
  function automatic pair_cat_e pair_cat(input logic hom1, input logic hom2,
                                         input logic [7:0] a1, input logic [7:0] b1,
                                         input logic [7:0] a2, input logic [7:0] b2);
    pair_cat_e c;
    if (hom1 != hom2) begin
      c = CAT_HOMHET;
    end else if (hom1) begin
      c = (a1 == a2) ? CAT_SAMEHOM : CAT_DIFFHOM;
    end else begin
      c = (a1 == a2 && b1 == b2) ? CAT_SAMEHET : CAT_DIFFHET;
    end
    return c;
  endfunction

  // One-hot mask for a counter index
  function automatic bump_mask_t bit_at(input logic [IDX_W-1:0] ix);
    return bump_mask_t'(1) << ix;
  endfunction

endpackage
`default_nettype wire

// ===== design/paired_genotype_concordance_counter.sv =====
// Top level: stream ports, front classifier, work queue and counter bank.
// Path: an accepted transaction is written into the two-entry queue, then popped
// into the result register once that register is empty or its result is taken.
// Throughput: one transaction per cycle while m_axis_tready is high; a held result
// stalls pops, and the two-entry queue keeps input accepting until it is full.
// Reset (rst_ni low, asynchronous) clears all 28 counters, the queue and the
// output valid at once; no clearing pass is needed.
`default_nettype none
module paired_genotype_concordance_counter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: site_base[7:0], first_mapped[8], first_called[9], first_allele_a[17:10],
  // first_allele_b[25:18], second_mapped[26], second_called[27],
  // second_allele_a[35:28], second_allele_b[43:36], counter_index[48:44], zero[55:49]
  input  wire logic [55:0] s_axis_tdata,
  // tuser: req_type[0]
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: site_class[2:0], pair_category[5:3], counter_value[37:6], zero[39:38]
  output logic [39:0]      m_axis_tdata
);

  gpcc_pkg::work_t       front_work, q_work;
  logic                  q_full, q_valid, q_pop;
  gpcc_pkg::site_class_e site_class;
  gpcc_pkg::pair_cat_e   pair_category;
  logic [31:0]           counter_value;

  gpcc_front u_front (
    .req_type_i        (s_axis_tuser),
    .site_base_i       (s_axis_tdata[7:0]),
    .first_mapped_i    (s_axis_tdata[8]),
    .first_called_i    (s_axis_tdata[9]),
    .first_allele_a_i  (s_axis_tdata[17:10]),
    .first_allele_b_i  (s_axis_tdata[25:18]),
    .second_mapped_i   (s_axis_tdata[26]),
    .second_called_i   (s_axis_tdata[27]),
    .second_allele_a_i (s_axis_tdata[35:28]),
    .second_allele_b_i (s_axis_tdata[43:36]),
    .counter_index_i   (s_axis_tdata[48:44]),
    .work_o            (front_work)
  );

  gpcc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_data_i (front_work),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_work)
  );

  assign s_axis_tready = !q_full;

  gpcc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .work_valid_i    (q_valid),
    .work_i          (q_work),
    .work_pop_o      (q_pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .site_class_o    (site_class),
    .pair_category_o (pair_category),
    .counter_value_o (counter_value)
  );

  // Pack result transaction
  assign m_axis_tdata = {2'b00, counter_value, pair_category, site_class};

endmodule
`default_nettype wire

// ===== design/gpcc_front.sv =====
// Front end: classifies one transaction into a counter bump mask and result codes.
`default_nettype none
module gpcc_front (
  input  wire logic                    req_type_i,
  input  wire logic [7:0]              site_base_i,
  input  wire logic                    first_mapped_i,
  input  wire logic                    first_called_i,
  input  wire logic [7:0]              first_allele_a_i,
  input  wire logic [7:0]              first_allele_b_i,
  input  wire logic                    second_mapped_i,
  input  wire logic                    second_called_i,
  input  wire logic [7:0]              second_allele_a_i,
  input  wire logic [7:0]              second_allele_b_i,
  input  wire logic [gpcc_pkg::IDX_W-1:0] counter_index_i,
  output gpcc_pkg::work_t              work_o
);

  logic [1:0] mapped, called, snp, hom;
  logic [7:0] aa [2];
  logic [7:0] ab [2];
  logic       agree;
  gpcc_pkg::pair_cat_e cat;

  assign mapped = {second_mapped_i, first_mapped_i};
  assign called = {second_called_i, first_called_i};
  assign aa[0] = first_allele_a_i;
  assign ab[0] = first_allele_b_i;
  assign aa[1] = second_allele_a_i;
  assign ab[1] = second_allele_b_i;

  // Per-sample genotype traits
  always_comb begin
    for (int s = 0; s < 2; s++) begin
      hom[s] = (aa[s] == ab[s]);
      snp[s] = called[s] && !(aa[s] == site_base_i && ab[s] == site_base_i);
    end
  end

  // Unordered genotype agreement and category
  assign agree = (aa[0] == aa[1] && ab[0] == ab[1]) || (ab[0] == aa[1] && aa[0] == ab[1]);
  assign cat   = gpcc_pkg::pair_cat(hom[0], hom[1], aa[0], ab[0], aa[1], ab[1]);

  // Build bump mask and result codes
  always_comb begin
    work_o.is_read    = req_type_i;
    work_o.idx        = counter_index_i;
    work_o.site_class = gpcc_pkg::SC_SKIPPED;
    work_o.cat        = gpcc_pkg::CAT_NONE;
    work_o.mask       = '0;
    if (!req_type_i && site_base_i != gpcc_pkg::BASE_N) begin
      for (int s = 0; s < 2; s++) begin
        if (mapped[s]) begin
          work_o.mask |= gpcc_pkg::bit_at(gpcc_pkg::IX_MAPPED + 5'(s));
        end
        if (called[s]) begin
          work_o.mask |= gpcc_pkg::bit_at(gpcc_pkg::IX_CALLED + 5'(s));
        end
        if (snp[s]) begin
          work_o.mask |= gpcc_pkg::bit_at(gpcc_pkg::IX_SNP + 5'(s));
          if (!hom[s]) begin
            work_o.mask |= gpcc_pkg::bit_at(gpcc_pkg::IX_SNP_HET + 5'(s));
          end
        end
      end
      if (&mapped) begin
        work_o.mask |= gpcc_pkg::bit_at(gpcc_pkg::IX_ALL_MAPPED);
      end else if (|mapped) begin
        work_o.mask |= gpcc_pkg::bit_at(gpcc_pkg::IX_SOME_MAPPED);
      end
      if (!(&called)) begin
        if (|called) begin
          work_o.mask |= gpcc_pkg::bit_at(gpcc_pkg::IX_SOME_CALLED);
        end
        work_o.site_class = gpcc_pkg::SC_NOT_BOTH;
      end else begin
        work_o.mask |= gpcc_pkg::bit_at(gpcc_pkg::IX_ALL_CALLED);
        if (agree) begin
          if (hom[0] && hom[1] && aa[0] == site_base_i) begin
            work_o.site_class = gpcc_pkg::SC_REF_AGREE;
          end else begin
            work_o.site_class = gpcc_pkg::SC_VAR_AGREE;
            work_o.cat        = cat;
            work_o.mask |= gpcc_pkg::bit_at(gpcc_pkg::IX_AGREE);
            work_o.mask |= gpcc_pkg::bit_at(gpcc_pkg::IX_AGREE_CAT + {2'b00, cat});
            for (int s = 0; s < 2; s++) begin
              if (!hom[s]) begin
                work_o.mask |= gpcc_pkg::bit_at(gpcc_pkg::IX_AGREE_HET + 5'(s));
              end else if (aa[s] != site_base_i) begin
                work_o.mask |= gpcc_pkg::bit_at(gpcc_pkg::IX_AGREE_HOM + 5'(s));
              end
            end
          end
        end else begin
          work_o.site_class = gpcc_pkg::SC_CONFLICT;
          work_o.cat        = cat;
          work_o.mask |= gpcc_pkg::bit_at(gpcc_pkg::IX_CONFLICT);
          work_o.mask |= gpcc_pkg::bit_at(gpcc_pkg::IX_CONFLICT_CAT + {2'b00, cat});
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/gpcc_fifo.sv =====
// Two-entry queue of classified transactions between front end and counter bank.
`default_nettype none
module gpcc_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire gpcc_pkg::work_t push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output gpcc_pkg::work_t      pop_data_o
);

  gpcc_pkg::work_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/gpcc_back.sv =====
// Back end: saturating counter bank and registered result stage.
`default_nettype none
module gpcc_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              work_valid_i,
  input  wire gpcc_pkg::work_t   work_i,
  output logic                   work_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output gpcc_pkg::site_class_e  site_class_o,
  output gpcc_pkg::pair_cat_e    pair_category_o,
  output logic [31:0]            counter_value_o
);

  gpcc_pkg::cnt_t cnt_q [gpcc_pkg::NUM_CNT];
  logic        out_valid_q, out_valid_d;
  gpcc_pkg::site_class_e class_q;
  gpcc_pkg::pair_cat_e   cat_q;
  logic [31:0] value_q, value_d;
  logic [63:0] wide;

  assign work_pop_o = work_valid_i && (!out_valid_q || out_ready_i);

  // Select requested counter, low 32 bits
  always_comb begin
    wide    = '0;
    value_d = '0;
    if (work_i.is_read && work_i.idx < gpcc_pkg::IDX_W'(gpcc_pkg::NUM_CNT)) begin
      wide    = 64'(cnt_q[work_i.idx]);
      value_d = wide[31:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (work_pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Bump counters, hold at maximum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < gpcc_pkg::NUM_CNT; i++) begin
        cnt_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (work_pop_o) begin
        for (int i = 0; i < gpcc_pkg::NUM_CNT; i++) begin
          if (work_i.mask[i] && cnt_q[i] != '1) begin
            cnt_q[i] <= cnt_q[i] + gpcc_pkg::cnt_t'(1);
          end
        end
      end
    end
  end

  // Load result register
  always_ff @(posedge clk_i) begin
    if (work_pop_o) begin
      class_q <= work_i.site_class;
      cat_q   <= work_i.cat;
      value_q <= value_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign site_class_o    = class_q;
  assign pair_category_o = cat_q;
  assign counter_value_o = value_q;

endmodule
`default_nettype wire

// ===== tb/gpcc_tb_pkg.sv =====
// Transaction types and the concordance scoreboard used by tb_top.
package gpcc_tb_pkg;
  import gpcc_pkg::*;

  // Site transaction laid out exactly as s_axis_tdata, highest field first
  typedef struct packed {
    logic [6:0] pad;
    logic [4:0] counter_index;
    logic [7:0] allele_b2;
    logic [7:0] allele_a2;
    logic       called2;
    logic       mapped2;
    logic [7:0] allele_b1;
    logic [7:0] allele_a1;
    logic       called1;
    logic       mapped1;
    logic [7:0] site_base;
  } site_item_t;

  // Result fields expected for one accepted transaction
  typedef struct {
    site_class_e cls;
    pair_cat_e   cat;
    logic [31:0] value;
  } verdict_t;

  class concordance_scoreboard;
    cnt_t     counts [NUM_CNT];
    verdict_t pending [$];
    int       errors;

    function new();
      foreach (counts[i]) counts[i] = '0;
      errors = 0;
    endfunction

    // Saturating increment of one statistic
    function void bump(int ix);
      if (counts[ix] != {CNT_W{1'b1}}) counts[ix] = counts[ix] + 1'b1;
    endfunction

    // Hom/het split of a called genotype pair
    function pair_cat_e zygosity_category(logic hom_a, logic hom_b,
                                          logic [7:0] a1, logic [7:0] b1,
                                          logic [7:0] a2, logic [7:0] b2);
      if (hom_a != hom_b) return CAT_HOMHET;
      if (hom_a) return (a1 == a2) ? CAT_SAMEHOM : CAT_DIFFHOM;
      return (a1 == a2 && b1 == b2) ? CAT_SAMEHET : CAT_DIFFHET;
    endfunction

    // Update the counter image for an accepted transaction and queue its verdict
    function void note_site(logic is_read, site_item_t it);
      verdict_t   v;
      logic [7:0] al_a [2];
      logic [7:0] al_b [2];
      logic       mp [2];
      logic       cl [2];
      logic       all_m, any_m, all_c, any_c, hom0, hom1, agree;
      pair_cat_e  c;
      v.cls   = SC_SKIPPED;
      v.cat   = CAT_NONE;
      v.value = '0;
      all_m = 1'b1; any_m = 1'b0; all_c = 1'b1; any_c = 1'b0;
      al_a[0] = it.allele_a1; al_b[0] = it.allele_b1;
      al_a[1] = it.allele_a2; al_b[1] = it.allele_b2;
      mp[0] = it.mapped1; cl[0] = it.called1;
      mp[1] = it.mapped2; cl[1] = it.called2;
      if (is_read) begin
        if (it.counter_index < NUM_CNT) v.value = counts[it.counter_index][31:0];
      end else if (it.site_base != BASE_N) begin
        // per-sample statistics
        for (int s = 0; s < 2; s++) begin
          if (mp[s]) begin
            bump(IX_MAPPED + s);
            any_m = 1'b1;
          end else begin
            all_m = 1'b0;
          end
          if (cl[s]) begin
            bump(IX_CALLED + s);
            if (!(al_a[s] == it.site_base && al_b[s] == it.site_base)) begin
              bump(IX_SNP + s);
              if (al_a[s] != al_b[s]) bump(IX_SNP_HET + s);
            end
            any_c = 1'b1;
          end else begin
            all_c = 1'b0;
          end
        end
        if (all_m) bump(IX_ALL_MAPPED);
        else if (any_m) bump(IX_SOME_MAPPED);
        // pair statistics only when both samples are called
        if (!all_c) begin
          if (any_c) bump(IX_SOME_CALLED);
          v.cls = SC_NOT_BOTH;
        end else begin
          bump(IX_ALL_CALLED);
          hom0  = (al_a[0] == al_b[0]);
          hom1  = (al_a[1] == al_b[1]);
          c     = zygosity_category(hom0, hom1, al_a[0], al_b[0], al_a[1], al_b[1]);
          agree = (al_a[0] == al_a[1] && al_b[0] == al_b[1]) ||
                  (al_b[0] == al_a[1] && al_a[0] == al_b[1]);
          if (agree) begin
            if (hom0 && hom1 && al_a[0] == it.site_base) begin
              v.cls = SC_REF_AGREE;
            end else begin
              bump(IX_AGREE);
              bump(IX_AGREE_CAT + int'(c));
              for (int s = 0; s < 2; s++) begin
                if (al_a[s] != al_b[s]) bump(IX_AGREE_HET + s);
                else if (al_a[s] != it.site_base) bump(IX_AGREE_HOM + s);
              end
              v.cls = SC_VAR_AGREE;
              v.cat = c;
            end
          end else begin
            bump(IX_CONFLICT);
            bump(IX_CONFLICT_CAT + int'(c));
            v.cls = SC_CONFLICT;
            v.cat = c;
          end
        end
      end
      pending.insert(pending.size(), v);
    endfunction

    // Compare one result transaction with the oldest verdict
    function void check_result(logic [39:0] d);
      verdict_t v;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction %h", d);
      end else begin
        v = pending.pop_front();
        if (d[2:0] !== v.cls || d[5:3] !== v.cat || d[37:6] !== v.value) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp class %0d cat %0d value %h, got class %0d cat %0d value %h",
                     v.cls, v.cat, v.value, d[2:0], d[5:3], d[37:6]);
        end
      end
    endfunction
  endclass
endpackage

// ===== tb/tb_top.sv =====
// Testbench top for the paired genotype concordance counter.
module tb_top;
  import gpcc_pkg::*;
  import gpcc_tb_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  concordance_scoreboard sb = new();
  bit calm = 1'b0;
  bit long_hold_req = 1'b0;

  paired_genotype_concordance_counter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Bound the run
  initial begin
    #4000000;
    $display("FAIL paired_genotype_concordance_counter");
    $finish;
  end

  // Check every accepted result transaction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Drive result backpressure: random bursts, one long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = 80;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one transaction and hold it until accepted
  task automatic offer(input logic is_read, input site_item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    s_axis_tuser  <= is_read;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_site(is_read, it);
  endtask

  // Drop valid for a random burst
  task automatic idle_burst();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 8)) @(posedge clk_i);
  endtask

  function automatic site_item_t site(logic [7:0] rb, logic m1, logic c1,
                                      logic [7:0] a1, logic [7:0] b1, logic m2,
                                      logic c2, logic [7:0] a2, logic [7:0] b2);
    site_item_t it;
    it = '0;
    it.site_base = rb;
    it.mapped1 = m1; it.called1 = c1; it.allele_a1 = a1; it.allele_b1 = b1;
    it.mapped2 = m2; it.called2 = c2; it.allele_a2 = a2; it.allele_b2 = b2;
    return it;
  endfunction

  function automatic site_item_t read_of(logic [4:0] ix);
    site_item_t it;
    it = '0;
    it.counter_index = ix;
    return it;
  endfunction

  // Mostly nucleotides so genotypes agree often, sometimes any byte
  function automatic logic [7:0] pick_base();
    case ($urandom_range(0, 9))
      0, 1:    return 8'($urandom_range(0, 255));
      2, 3:    return "A";
      4, 5:    return "C";
      6, 7:    return "G";
      default: return "T";
    endcase
  endfunction

  // Random site: sample two often copies or perturbs sample one
  function automatic site_item_t random_site();
    site_item_t it;
    logic [7:0] alt;
    it = '0;
    it.site_base = ($urandom_range(0, 9) == 0) ? BASE_N : pick_base();
    it.mapped1 = ($urandom_range(0, 4) != 0);
    it.called1 = ($urandom_range(0, 4) != 0);
    it.mapped2 = ($urandom_range(0, 4) != 0);
    it.called2 = ($urandom_range(0, 4) != 0);
    it.counter_index = 5'($urandom_range(0, 31));
    alt = pick_base();
    case ($urandom_range(0, 3))
      0: begin it.allele_a1 = it.site_base; it.allele_b1 = it.site_base; end
      1: begin it.allele_a1 = it.site_base; it.allele_b1 = alt; end
      2: begin it.allele_a1 = alt; it.allele_b1 = alt; end
      default: begin it.allele_a1 = pick_base(); it.allele_b1 = pick_base(); end
    endcase
    case ($urandom_range(0, 3))
      0: begin it.allele_a2 = it.allele_a1; it.allele_b2 = it.allele_b1; end
      1: begin it.allele_a2 = it.allele_b1; it.allele_b2 = it.allele_a1; end
      2: begin it.allele_a2 = it.allele_a1; it.allele_b2 = pick_base(); end
      default: begin it.allele_a2 = pick_base(); it.allele_b2 = pick_base(); end
    endcase
    return it;
  endfunction

  // Main stimulus
  initial begin
    bit is_read;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: skip, partial calls, every agreement and conflict kind, extremes
    offer(1'b0, site(BASE_N, 1, 1, "C", "C", 1, 1, "C", "C"));
    offer(1'b0, site("A", 1, 1, "A", "C", 1, 0, "A", "C"));
    offer(1'b0, site("A", 0, 0, "A", "A", 0, 0, "A", "A"));
    offer(1'b0, site("A", 1, 0, "G", "G", 1, 0, "G", "G"));
    offer(1'b0, site("A", 0, 1, "A", "A", 1, 1, "A", "A"));
    offer(1'b0, site("A", 1, 1, "C", "C", 1, 1, "C", "C"));
    offer(1'b0, site("A", 1, 1, "A", "A", 1, 1, "C", "C"));
    offer(1'b0, site("A", 1, 1, "A", "C", 1, 1, "A", "C"));
    offer(1'b0, site("A", 1, 1, "A", "C", 1, 1, "C", "A"));
    offer(1'b0, site("T", 1, 1, "C", "G", 1, 1, "G", "C"));
    offer(1'b0, site("A", 1, 1, "A", "C", 1, 1, "A", "G"));
    offer(1'b0, site("A", 1, 1, "A", "A", 1, 1, "A", "C"));
    offer(1'b0, site("G", 1, 1, "T", "T", 1, 1, "C", "C"));
    offer(1'b0, site(8'h00, 1, 1, 8'hFF, 8'h00, 1, 1, 8'h00, 8'hFF));
    offer(1'b0, site(8'hFF, 1, 1, 8'hFF, 8'hFF, 1, 1, 8'hFF, 8'hFF));
    offer(1'b0, site(8'hFF, 1, 1, 8'h00, 8'h00, 1, 1, 8'h00, 8'h00));
    offer(1'b1, read_of(IX_MAPPED));
    offer(1'b1, read_of(IX_AGREE));
    offer(1'b1, read_of(IX_CONFLICT));
    offer(1'b1, read_of(5'(NUM_CNT - 1)));
    offer(1'b1, read_of(5'(NUM_CNT)));
    offer(1'b1, read_of(5'd31));

    // Random traffic
    for (int n = 0; n < 1030; n++) begin
      calm = (n >= 880);
      if (n == 300) long_hold_req = 1'b1;
      if (n == 600) begin
        // pause until the block has drained
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (sb.pending.size() != 0) @(posedge clk_i);
      end
      if (!calm && !(n >= 300 && n < 340) && $urandom_range(0, 5) == 0) idle_burst();
      is_read = ($urandom_range(0, 99) < 15);
      offer(is_read, random_site());
    end
    s_axis_tvalid <= 1'b0;

    // Drain and settle
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS paired_genotype_concordance_counter");
    end else begin
      $display("FAIL paired_genotype_concordance_counter");
    end
    $finish;
  end
endmodule
